[hdl/accel_value_to_rgb_colormap_macros.svh]
// Assertion macros for the colormap checker.
`ifndef ACCEL_VALUE_TO_RGB_COLORMAP_MACROS_SVH
`define ACCEL_VALUE_TO_RGB_COLORMAP_MACROS_SVH

// A stalled beat keeps its valid and its data.
`define ACCEL_ASSERT_HOLD(lbl, ck, rn, vld, rdy, dat) \
	lbl: assert property (@(posedge ck) disable iff (!rn) \
		(vld && !rdy) |=> (vld && $stable(dat))) \
		else $error("stalled beat changed");

// Plain implication, checked in the same cycle.
`define ACCEL_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

[hdl/avrgb_pkg.sv]
// Types, coefficient tables and legend tables for the acceleration colormap.
`timescale 1ns / 1ps
`default_nettype none
package avrgb_pkg;

	localparam int NW      = 55;
	localparam int DW      = 47;
	localparam int SQW     = 36;
	localparam int UW      = 28;
	localparam int QW      = 8;
	localparam int DIV_STG = 8;
	localparam int SW      = 64;
	localparam int C2W     = 26;
	localparam int C1W     = 29;
	localparam int C0W     = 36;
	localparam int SCW     = 27;

	typedef struct packed {
		logic signed [C2W-1:0] c2;
		logic signed [C1W-1:0] c1;
		logic signed [C0W-1:0] c0;
		logic [SCW-1:0]        sc;
	} coef_t;

	// thresholds in units of 1e-4 gal
	localparam longint unsigned RED_THR [7] = '{
		98, 392, 784, 980, 9800, 1470000, 2450000};
	localparam longint unsigned GREEN_THR [3] = '{9800, 98000, 2450000};
	localparam longint unsigned BLUE_THR [4] = '{98, 980, 9800, 39200};

	// gradient breakpoints in hundredths of a gal
	localparam longint unsigned GRAD_BP [10] = '{
		0, 98, 294, 490, 2352, 6566, 12740, 23520, 43120, 81340};
	localparam logic [23:0] GRAD_RGB [10] = '{
		24'hFFFFFF, 24'hA5DDF9, 24'h92D050, 24'hFFFF00, 24'hFFC000,
		24'hFF0000, 24'hA32777, 24'h632523, 24'h4C2600, 24'h000000};

	function automatic coef_t mk(longint c2, longint c1, longint c0, longint sc);
		coef_t c;
		c.c2 = C2W'(c2);
		c.c1 = C1W'(c1);
		c.c0 = C0W'(c0);
		c.sc = SCW'(sc);
		return c;
	endfunction

	function automatic coef_t red_coef(logic [2:0] seg);
		unique case (seg)
			3'd0: return mk(0, 0, 191, 1);
			3'd1: return mk(0, -326531, 22300, 100);
			3'd2: return mk(0, 0, 95, 1);
			3'd3: return mk(0, 326531, -16100, 100);
			3'd4: return mk(0, 103820, 148497, 1000);
			3'd5: return mk(0, 0, 255, 1);
			3'd6: return mk(-333195, 81632700, 64'sd20700000000, 100000000);
			default: return mk(0, 0, 207, 1);
		endcase
	endfunction

	function automatic coef_t green_coef(logic [1:0] seg);
		unique case (seg)
			2'd0: return mk(0, 0, 255, 1);
			2'd1: return mk(-757260, -627943, 255448000, 1000000);
			2'd2: return mk(432696, -184309000, 64'sd19278400000, 100000000);
			default: return mk(0, 0, 0, 1);
		endcase
	endfunction

	function automatic coef_t blue_coef(logic [2:0] seg);
		unique case (seg)
			3'd0: return mk(0, 0, 255, 1);
			3'd1: return mk(-19799200, 538854, 260429, 1000);
			3'd2: return mk(-354966, -658163, 1162640, 10000);
			3'd3: return mk(0, -510204, 2000000, 100000);
			default: return mk(0, 0, 0, 1);
		endcase
	endfunction

endpackage
`default_nettype wire

[hdl/avrgb_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for one colour lane.
`timescale 1ns / 1ps
`default_nettype none
module avrgb_div
	import avrgb_pkg::*;
(
	input  logic               clk,
	input  logic [DIV_STG-1:0] ce,
	input  logic [NW-1:0]      num,
	input  logic [DW-1:0]      den,
	output logic [QW-1:0]      quo
);

	logic [NW-1:0] rem_s [DIV_STG];
	logic [DW-1:0] den_s [DIV_STG];
	logic [QW-1:0] quo_s [DIV_STG];

	for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [NW:0]   trial;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		assign trial = {1'b0, rem_in} - ((NW+1)'(den_in) << (DIV_STG-1-j));

		// keep the difference when it does not go negative
		always_ff @(posedge clk) begin
			if (ce[j]) begin
				den_s[j] <= den_in;
				if (!trial[NW]) begin
					rem_s[j] <= trial[NW-1:0];
					quo_s[j] <= quo_in | (QW'(1) << (DIV_STG-1-j));
				end else begin
					rem_s[j] <= rem_in;
					quo_s[j] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[DIV_STG-1];

endmodule
`default_nettype wire

[hdl/accel_value_to_rgb_colormap.sv]
// Top level: acceleration value to RGB colour, polynomial or gradient legend.
//
// channel   dir  fields (lowest bit up)
// s_*       in   tdata: accel_value[23:0]
// m_*       out  tdata: red_level[7:0], green_level[15:8], blue_level[23:16]
// legend_*  in   write enable and 1-bit mode, taken at any clock edge
//
// One beat a cycle unless m_tready stalls the output, through fourteen register stages:
// six arithmetic stages (segment lookup, square, coefficient products, sums) and eight
// divider stages.
// Each stage moves on when it is empty or the next one moves, so bubbles close up.
// Reset clears the mode register and the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module accel_value_to_rgb_colormap
	import avrgb_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        legend_mode_we,
	input  logic        legend_mode_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // accel_value[23:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // red_level[7:0], green_level[15:8], blue_level[23:16]
);

	localparam int NSTG = 6 + DIV_STG;
	localparam int XW   = (FRAC_BITS + 8 > 24) ? 24 : FRAC_BITS + 8;
	localparam int HW   = (XW + 1) / 2;
	localparam int HIW  = XW - HW;
	localparam int PW   = FRAC_BITS + 17;

	function automatic longint unsigned cthr(longint unsigned a);
		return (a << FRAC_BITS) / 10000;
	endfunction

	function automatic longint unsigned gthr(longint unsigned b);
		return ((b << FRAC_BITS) + 99) / 100;
	endfunction

	logic            mode_q;
	logic [NSTG-1:0] v_q;
	logic [NSTG-1:0] ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (legend_mode_we) begin
			mode_q <= legend_mode_wdata;
		end
	end

	// advance a stage when it is empty or its successor advances
	always_comb begin
		ce[NSTG-1] = !v_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			ce[k] = !v_q[k] || ce[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ce[0]) v_q[0] <= s_tvalid;
			for (int k = 1; k < NSTG; k++) begin
				if (ce[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign s_tready = ce[0];
	assign m_tvalid = v_q[NSTG-1];

	// stage 1
	logic [23:0] x_s1;
	logic        mode_s1;

	always_ff @(posedge clk) begin
		if (ce[0]) begin
			x_s1    <= s_tdata;
			mode_s1 <= mode_q;
		end
	end

	logic [63:0]   xw;
	logic [2:0]    rseg;
	logic [1:0]    gseg;
	logic [2:0]    bseg;
	logic [3:0]    gidx;
	logic          gtop;
	logic [XW-1:0] xc;

	always_comb begin
		xw   = 64'(x_s1);
		rseg = '0;
		gseg = '0;
		bseg = '0;
		gidx = '0;
		for (int i = 0; i < 7; i++) begin
			if (xw > cthr(RED_THR[i])) rseg = 3'(i + 1);
		end
		for (int i = 0; i < 3; i++) begin
			if (xw > cthr(GREEN_THR[i])) gseg = 2'(i + 1);
		end
		for (int i = 0; i < 4; i++) begin
			if (xw > cthr(BLUE_THR[i])) bseg = 3'(i + 1);
		end
		for (int i = 1; i < 9; i++) begin
			if (xw >= gthr(GRAD_BP[i])) gidx = 4'(i);
		end
		gtop = xw >= gthr(GRAD_BP[9]);
		// beyond the last curve every channel is constant, so drop the value
		xc = (xw <= cthr(GREEN_THR[2])) ? x_s1[XW-1:0] : '0;
	end

	// stage 2
	logic [2:0]    rseg_s2;
	logic [1:0]    gseg_s2;
	logic [2:0]    bseg_s2;
	logic [3:0]    gidx_s2;
	logic          gtop_s2;
	logic          mode_s2;
	logic [XW-1:0] xc_s2;
	logic [23:0]   x_s2;

	always_ff @(posedge clk) begin
		if (ce[1]) begin
			rseg_s2 <= rseg;
			gseg_s2 <= gseg;
			bseg_s2 <= bseg;
			gidx_s2 <= gidx;
			gtop_s2 <= gtop;
			mode_s2 <= mode_s1;
			xc_s2   <= xc;
			x_s2    <= x_s1;
		end
	end

	logic [2*HIW-1:0]  pp_hh;
	logic [HIW+HW-1:0] pp_hl;
	logic [2*HW-1:0]   pp_ll;
	logic [39:0]       gp;
	logic [39:0]       glo;
	logic [39:0]       ghi;
	logic [PW-1:0]     ga;
	logic [PW-1:0]     gb;
	logic [PW-1:0]     gden;
	logic [23:0]       ecol;
	logic [23:0]       scol;
	coef_t             cf [3];

	always_comb begin
		pp_hh = xc_s2[XW-1:HW] * xc_s2[XW-1:HW];
		pp_hl = xc_s2[XW-1:HW] * xc_s2[HW-1:0];
		pp_ll = xc_s2[HW-1:0] * xc_s2[HW-1:0];
		gp    = 40'(x_s2) * 40'd100;
		glo   = 40'(GRAD_BP[gidx_s2]) << FRAC_BITS;
		ghi   = 40'(GRAD_BP[4'(gidx_s2 + 4'd1)]) << FRAC_BITS;
		ecol  = GRAD_RGB[gidx_s2];
		scol  = GRAD_RGB[4'(gidx_s2 + 4'd1)];
		if (gtop_s2) begin
			ga   = '0;
			gb   = '0;
			gden = PW'(1);
		end else begin
			ga   = PW'(ghi - gp);
			gb   = PW'(gp - glo);
			gden = PW'(ghi - glo);
		end
		cf[0] = red_coef(rseg_s2);
		cf[1] = green_coef(gseg_s2);
		cf[2] = blue_coef(bseg_s2);
	end

	// stage 3
	logic [2*HIW-1:0]  pp_hh_s3;
	logic [HIW+HW-1:0] pp_hl_s3;
	logic [2*HW-1:0]   pp_ll_s3;
	logic [XW-1:0]     xc_s3;
	coef_t             cf_s3 [3];
	logic [PW-1:0]     ga_s3;
	logic [PW-1:0]     gb_s3;
	logic [PW-1:0]     gden_s3;
	logic [23:0]       ecol_s3;
	logic [23:0]       scol_s3;
	logic              mode_s3;

	always_ff @(posedge clk) begin
		if (ce[2]) begin
			pp_hh_s3 <= pp_hh;
			pp_hl_s3 <= pp_hl;
			pp_ll_s3 <= pp_ll;
			xc_s3    <= xc_s2;
			cf_s3    <= cf;
			ga_s3    <= ga;
			gb_s3    <= gb;
			gden_s3  <= gden;
			ecol_s3  <= ecol;
			scol_s3  <= scol;
			mode_s3  <= mode_s2;
		end
	end

	logic [63:0]     xxw;
	logic [SQW-1:0]  sq;
	logic [UW-1:0]   u;
	logic [PW+7:0]   gpe [3];
	logic [PW+7:0]   gps [3];

	always_comb begin
		// v^2 in Q20, truncated
		xxw = ((64'(pp_hh_s3) << (2 * HW)) + (64'(pp_hl_s3) << (HW + 1))
			+ 64'(pp_ll_s3)) << (40 - 2 * FRAC_BITS);
		sq  = xxw[SQW+19:20];
		u   = UW'(64'(xc_s3) << (20 - FRAC_BITS));
		for (int ch = 0; ch < 3; ch++) begin
			gpe[ch] = (PW+8)'(ecol_s3[23-8*ch -: 8]) * (PW+8)'(ga_s3);
			gps[ch] = (PW+8)'(scol_s3[23-8*ch -: 8]) * (PW+8)'(gb_s3);
		end
	end

	// stage 4
	logic [SQW-1:0] sq_s4;
	logic [UW-1:0]  u_s4;
	coef_t          cf_s4 [3];
	logic [PW+7:0]  gpe_s4 [3];
	logic [PW+7:0]  gps_s4 [3];
	logic [PW-1:0]  gden_s4;
	logic           mode_s4;

	always_ff @(posedge clk) begin
		if (ce[3]) begin
			sq_s4   <= sq;
			u_s4    <= u;
			cf_s4   <= cf_s3;
			gpe_s4  <= gpe;
			gps_s4  <= gps;
			gden_s4 <= gden_s3;
			mode_s4 <= mode_s3;
		end
	end

	logic signed [C2W+18:0]  m2h [3];
	logic signed [C2W+18:0]  m2l [3];
	logic signed [C1W+UW:0]  m1 [3];
	logic [PW+8:0]           gnum [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			m2h[ch]  = $signed(cf_s4[ch].c2) * $signed({1'b0, sq_s4[SQW-1:18]});
			m2l[ch]  = $signed(cf_s4[ch].c2) * $signed({1'b0, sq_s4[17:0]});
			m1[ch]   = $signed(cf_s4[ch].c1) * $signed({1'b0, u_s4});
			gnum[ch] = (PW+9)'(gpe_s4[ch]) + (PW+9)'(gps_s4[ch]);
		end
	end

	// stage 5
	logic signed [C2W+18:0] m2h_s5 [3];
	logic signed [C2W+18:0] m2l_s5 [3];
	logic signed [C1W+UW:0] m1_s5 [3];
	logic signed [C0W-1:0]  c0_s5 [3];
	logic [SCW-1:0]         sc_s5 [3];
	logic [PW+8:0]          gnum_s5 [3];
	logic [PW-1:0]          gden_s5;
	logic                   mode_s5;

	always_ff @(posedge clk) begin
		if (ce[4]) begin
			m2h_s5  <= m2h;
			m2l_s5  <= m2l;
			m1_s5   <= m1;
			for (int ch = 0; ch < 3; ch++) begin
				c0_s5[ch] <= cf_s4[ch].c0;
				sc_s5[ch] <= cf_s4[ch].sc;
			end
			gnum_s5 <= gnum;
			gden_s5 <= gden_s4;
			mode_s5 <= mode_s4;
		end
	end

	logic signed [SW-1:0] t2 [3];
	logic signed [SW-1:0] t1 [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			t2[ch] = (SW'(m2h_s5[ch]) <<< 18) + SW'(m2l_s5[ch]);
			t1[ch] = SW'(m1_s5[ch]) + (SW'(c0_s5[ch]) <<< 20);
		end
	end

	// stage 6
	logic signed [SW-1:0] t2_s6 [3];
	logic signed [SW-1:0] t1_s6 [3];
	logic [SCW-1:0]       sc_s6 [3];
	logic [PW+8:0]        gnum_s6 [3];
	logic [PW-1:0]        gden_s6;
	logic                 mode_s6;

	always_ff @(posedge clk) begin
		if (ce[5]) begin
			t2_s6   <= t2;
			t1_s6   <= t1;
			sc_s6   <= sc_s5;
			gnum_s6 <= gnum_s5;
			gden_s6 <= gden_s5;
			mode_s6 <= mode_s5;
		end
	end

	logic signed [SW-1:0] num [3];
	logic [DW-1:0]        den [3];
	logic [NW-1:0]        lim [3];
	logic [NW-1:0]        dnum [3];

	// saturate to 0..255 ahead of the divider
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			num[ch] = mode_s6 ? $signed(SW'(gnum_s6[ch])) : t2_s6[ch] + t1_s6[ch];
			den[ch] = mode_s6 ? DW'(gden_s6) : {sc_s6[ch], 20'd0};
			lim[ch] = {den[ch], 8'd0};
			if (num[ch] < 0) begin
				dnum[ch] = '0;
			end else if (num[ch] >= $signed(SW'(lim[ch]))) begin
				dnum[ch] = lim[ch] - NW'(den[ch]);
			end else begin
				dnum[ch] = NW'(num[ch]);
			end
		end
	end

	logic [QW-1:0] level [3];

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		avrgb_div u_div (
			.clk (clk),
			.ce  (ce[NSTG-1:6]),
			.num (dnum[ch]),
			.den (den[ch]),
			.quo (level[ch])
		);
	end

	assign m_tdata = {level[2], level[1], level[0]};

endmodule
`default_nettype wire

[hdl/avrgb_chk.sv]
// Port checker for the colormap, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "accel_value_to_rgb_colormap_macros.svh"
module avrgb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	`ACCEL_ASSERT_HOLD(a_out_hold, clk, arst_n, m_tvalid, m_tready, m_tdata)
	`ACCEL_ASSERT_IMPLY(a_ready_passes, clk, arst_n, m_tready, s_tready)
	`ACCEL_ASSERT_IMPLY(a_empty_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind accel_value_to_rgb_colormap avrgb_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

[test/tb_accel_value_to_rgb_colormap.sv]
// Self-checking testbench for the acceleration-to-colour legend block.
`timescale 1ns / 1ps
`default_nettype none
module tb_accel_value_to_rgb_colormap;
	import avrgb_pkg::*;

	localparam int FRAC   = 14;
	localparam int LIMIT  = 600000;
	localparam int SETTLE = 30;

	typedef enum logic { MODE_CURVES = 1'b0, MODE_GRADIENT = 1'b1 } legend_e;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} colour_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        legend_mode_we = 1'b0;
	logic        legend_mode_wdata = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	legend_e     cur_mode = MODE_CURVES;
	logic [23:0] accel_fifo[$];
	colour_t     colour_fifo[$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          err_count = 0;
	int          cycle_count = 0;
	bit          in_taken = 1'b0;

	always #5 clk = ~clk;

	accel_value_to_rgb_colormap #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.legend_mode_we(legend_mode_we), .legend_mode_wdata(legend_mode_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// v <= a / 10000 gal, exactly
	function automatic bit at_most(longint unsigned x, longint unsigned a);
		return x * 10000 <= (a << FRAC);
	endfunction

	function automatic logic [7:0] seg_val(longint u, longint c2, longint c1, longint c0,
	                                       longint s);
		longint sq, num, q;
		sq = longint'((longint'(unsigned'(u)) * u) >>> 20);
		num = c2 * sq + c1 * u + c0 * (longint'(1) << 20);
		q = num / (s * (longint'(1) << 20));
		if (q < 0) q = 0;
		if (q > 255) q = 255;
		return q[7:0];
	endfunction

	function automatic colour_t map_colour(legend_e mode, logic [23:0] accel);
		colour_t c;
		longint unsigned x, p, lo, hi, e, s, q;
		longint u;
		int idx;
		x = accel;
		if (mode == MODE_GRADIENT) begin
			p = x * 100;
			if (p >= (GRAD_BP[9] << FRAC)) return '0;
			idx = 0;
			for (int i = 1; i < 9; i++)
				if (p >= (GRAD_BP[i] << FRAC)) idx = i;
			lo = GRAD_BP[idx] << FRAC;
			hi = GRAD_BP[idx + 1] << FRAC;
			for (int ch = 0; ch < 3; ch++) begin
				e = (GRAD_RGB[idx] >> (16 - 8 * ch)) & 8'hFF;
				s = (GRAD_RGB[idx + 1] >> (16 - 8 * ch)) & 8'hFF;
				q = (e * (hi - p) + s * (p - lo)) / (hi - lo);
				if (q > 255) q = 255;
				if (ch == 0) c.red = q[7:0];
				else if (ch == 1) c.green = q[7:0];
				else c.blue = q[7:0];
			end
			return c;
		end
		u = longint'(x << (20 - FRAC));
		if (at_most(x, 98)) c.red = 191;
		else if (at_most(x, 392)) c.red = seg_val(u, 0, -326531, 22300, 100);
		else if (at_most(x, 784)) c.red = 95;
		else if (at_most(x, 980)) c.red = seg_val(u, 0, 326531, -16100, 100);
		else if (at_most(x, 9800)) c.red = seg_val(u, 0, 103820, 148497, 1000);
		else if (at_most(x, 1470000)) c.red = 255;
		else if (at_most(x, 2450000))
			c.red = seg_val(u, -333195, 81632700, 64'sd20700000000, 100000000);
		else c.red = 207;
		if (at_most(x, 9800)) c.green = 255;
		else if (at_most(x, 98000))
			c.green = seg_val(u, -757260, -627943, 255448000, 1000000);
		else if (at_most(x, 2450000))
			c.green = seg_val(u, 432696, -184309000, 64'sd19278400000, 100000000);
		else c.green = 0;
		if (at_most(x, 98)) c.blue = 255;
		else if (at_most(x, 980)) c.blue = seg_val(u, -19799200, 538854, 260429, 1000);
		else if (at_most(x, 9800)) c.blue = seg_val(u, -354966, -658163, 1162640, 10000);
		else if (at_most(x, 39200)) c.blue = seg_val(u, 0, -510204, 2000000, 100000);
		else c.blue = 0;
		return c;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
		         cycle_count);
		err_count++;
	endtask

	// accept, predict and check at the rising edge
	always @(posedge clk) begin
		colour_t want, got;
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
		in_taken = s_tvalid && s_tready;
		if (in_taken) colour_fifo.push_back(map_colour(cur_mode, s_tdata));
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (colour_fifo.size() == 0) begin
				$display("unexpected beat %h at cycle %0d", m_tdata, cycle_count);
				err_count++;
			end else begin
				want = colour_fifo.pop_front();
				if (got.red !== want.red) report_mismatch("red", got.red, want.red);
				if (got.green !== want.green)
					report_mismatch("green", got.green, want.green);
				if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
			end
		end
	end

	// drive a new beat once the current one has gone
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (accel_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= accel_fifo.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= $urandom_range(99) >= recv_stall_pct;
	end

	function automatic logic [23:0] rand_accel();
		longint unsigned marks[17] = '{98, 392, 784, 980, 9800, 39200, 98000, 1470000,
			2450000, 29400, 49000, 235200, 656600, 1274000, 2352000, 4312000, 8134000};
		longint unsigned b;
		int k;
		k = $urandom_range(2);
		if (k == 0) return 24'($urandom);
		if (k == 1) return 24'($urandom_range(4200000));
		b = (marks[$urandom_range(16)] << FRAC) / 10000;
		return 24'(b + $urandom_range(6) - 3);
	endfunction

	task automatic set_mode(legend_e m);
		@(negedge clk);
		legend_mode_we <= 1'b1;
		legend_mode_wdata <= m;
		@(negedge clk);
		legend_mode_we <= 1'b0;
		cur_mode = m;
	endtask

	task automatic drain();
		while (accel_fifo.size() != 0 || s_tvalid || colour_fifo.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [23:0] directed[$];
		longint unsigned marks[10] = '{98, 392, 784, 980, 9800, 39200, 98000, 1470000,
			2450000, 8134000};
		directed = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, 24'h7FFFFF,
		             24'h555555, 24'hAAAAAA};
		// both sides of every curve threshold, top gradient breakpoint included
		foreach (marks[i]) begin
			directed.push_back(24'((marks[i] << FRAC) / 10000));
			directed.push_back(24'((marks[i] << FRAC) / 10000 + 1));
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);
		for (int m = 0; m < 2; m++) begin
			set_mode(legend_e'(m));
			foreach (directed[i]) accel_fifo.push_back(directed[i]);
			drain();
		end
		for (int ph = 0; ph < 8; ph++) begin
			set_mode(legend_e'(ph % 2));
			send_idle_pct = (ph / 2 == 1 || ph / 2 == 3) ? ((ph / 2 == 3) ? 26 : 52) : 0;
			recv_stall_pct = (ph / 2 == 2 || ph / 2 == 3) ? ((ph / 2 == 3) ? 26 : 52) : 0;
			repeat (210) accel_fifo.push_back(rand_accel());
			drain();
		end
		if (err_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/avrgb_pkg.sv
hdl/avrgb_div.sv
hdl/accel_value_to_rgb_colormap.sv
hdl/avrgb_chk.sv
test/tb_accel_value_to_rgb_colormap.sv
